// ===== hdl/fep_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fep_pkg;

   localparam int MAX_WIDTH   = 128;
   localparam int MAX_HEIGHT  = 64;
   localparam int HEAT_LEVELS = 13;
   localparam int STORE_CELLS = MAX_WIDTH * MAX_HEIGHT;

   localparam int CELL_W   = $clog2(STORE_CELLS);
   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int ROW_W    = $clog2(MAX_HEIGHT);
   localparam int WIDTH_W  = 8;
   localparam int HEIGHT_W = 7;
   localparam int PROD_W   = WIDTH_W + HEIGHT_W;
   localparam int LEVEL_W  = 4;
   localparam int RAND_W   = 2;
   localparam int GLYPH_W  = 14;
   localparam int FG_W     = 4;
   localparam int BG_W     = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [LEVEL_W-1:0]  TOP_LEVEL    = LEVEL_W'(HEAT_LEVELS - 1);
   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 8'd80;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 7'd24;
   localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = 8'd1;
   localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
   localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = 7'd2;
   localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = HEIGHT_W'(MAX_HEIGHT);

   // Operation codes of an input item.
   localparam logic OP_SEED      = 1'b0;
   localparam logic OP_PROPAGATE = 1'b1;

   // Register indexes on the configuration channel.
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   // Palette.
   localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 14'd32;
   localparam logic [GLYPH_W-1:0] SHADE_GLYPH [4] = '{14'h2591, 14'h2592, 14'h2593, 14'h2588};
   localparam logic [FG_W-1:0] FG_COLD = 4'd9;
   localparam logic [FG_W-1:0] FG_LOW  = 4'd2;
   localparam logic [FG_W-1:0] FG_MID  = 4'd4;
   localparam logic [FG_W-1:0] FG_HIGH = 4'd8;
   localparam logic [BG_W-1:0] BG_LOW  = 3'd0;
   localparam logic [BG_W-1:0] BG_MID  = 3'd2;
   localparam logic [BG_W-1:0] BG_HIGH = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MODIFY,
      ST_DST,
      ST_SRC
   } fep_state_type;

endpackage

`default_nettype wire

// ===== hdl/fep_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface fep_req_if
   import fep_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              operation;
   logic [RAND_W-1:0] rand_value;

   modport source (output valid, operation, rand_value, input ready);
   modport sink   (input valid, operation, rand_value, output ready);
endinterface

interface fep_rsp_if
   import fep_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [CELL_W-1:0]  cell_index;
   logic [LEVEL_W-1:0] heat_level;
   logic [GLYPH_W-1:0] glyph_code;
   logic [FG_W-1:0]    foreground;
   logic [BG_W-1:0]    background;
   logic               last_of_run;
   logic               frame_end;

   modport source (output valid, cell_index, heat_level, glyph_code, foreground, background,
                   last_of_run, frame_end, input ready);
   modport sink   (input valid, cell_index, heat_level, glyph_code, foreground, background,
                   last_of_run, frame_end, output ready);
endinterface

interface fep_csr_if
   import fep_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/fep_palette.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fep_palette
   import fep_pkg::*;
(
   input  wire logic [LEVEL_W-1:0] level,
   output logic      [GLYPH_W-1:0] glyph_code,
   output logic      [FG_W-1:0]    foreground,
   output logic      [BG_W-1:0]    background
);

   logic [LEVEL_W-1:0] level_less;

   assign level_less = level - LEVEL_W'(1);

   always_comb begin
      glyph_code = GLYPH_SPACE;
      foreground = FG_COLD;
      background = BG_LOW;
      // Levels above the top one read as cold.
      if (level != '0 && level <= TOP_LEVEL) begin
         glyph_code = SHADE_GLYPH[level_less[1:0]];
         case (level_less[LEVEL_W-1:2])
            2'd0: begin
               foreground = FG_LOW;
               background = BG_LOW;
            end
            2'd1: begin
               foreground = FG_MID;
               background = BG_MID;
            end
            default: begin
               foreground = FG_HIGH;
               background = BG_HIGH;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== hdl/fire_effect_propagate_unit.sv =====
// Fire effect propagation unit.
// Items arrive on req_chan (valid/ready); results leave on rsp_chan (valid/ready);
// the field size is set through csr_chan (index 0 frame width, index 1 frame height),
// which is always ready; the user must write it only while the unit is idle, which the unit does not enforce.
// A seed item writes the next cell in linear order and gives one result in the
// output register at the edge that accepts it, so seeds flow at one item a cycle while the receiver takes each result.
// A propagate item reads its source cell from the heat store through a registered
// read, writes the decayed level to the destination in the next cycle and gives
// two results, destination first; its steps are accept and read, modify and write
// with the destination result, then the source result. The registered read of the
// heat store and the single output register set these steps.
// A single output register holds the waiting result; when the receiver stalls,
// the unit finishes the write and waits with its next result, and it takes no new
// item until the output register can be loaded.
// Reset clears the counters (seed position 0, column 0, row 1) and restores
// width 80 and height 24. The heat store is not cleared: cells must be seeded
// before they are propagated.
`timescale 1ns / 1ps
`default_nettype none

module fire_effect_propagate_unit
   import fep_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   fep_req_if.sink   req_chan,
   fep_rsp_if.source rsp_chan,
   fep_csr_if.sink   csr_chan
);

   fep_state_type state_ff, state_in;

   logic [WIDTH_W-1:0]  width_ff, width_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;
   logic [CELL_W-1:0]   seed_ff, seed_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;

   logic [CELL_W-1:0]  src_ff, src_in;
   logic [CELL_W-1:0]  dst_ff, dst_in;
   logic               decay_ff, decay_in;
   logic               fend_ff, fend_in;
   logic [LEVEL_W-1:0] dst_lvl_ff, dst_lvl_in;
   logic [LEVEL_W-1:0] src_lvl_ff, src_lvl_in;

   logic               out_valid_ff, out_valid_in;
   logic [CELL_W-1:0]  out_cell_ff, out_cell_in;
   logic [LEVEL_W-1:0] out_lvl_ff, out_lvl_in;
   logic               out_last_ff, out_last_in;
   logic               out_fend_ff, out_fend_in;

   logic [LEVEL_W-1:0] heat_mem [STORE_CELLS];
   logic [LEVEL_W-1:0] rd_data_ff;

   logic               out_free, req_ready, req_accept;
   logic               load_seed, load_prop, load_dst, load_src;
   logic               mem_we;
   logic [CELL_W-1:0]  mem_waddr;
   logic [LEVEL_W-1:0] mem_wdata;

   // Seed address arithmetic.
   logic [PROD_W-1:0]  total, bottom;
   logic [CELL_W-1:0]  seed_pos;
   logic [LEVEL_W-1:0] seed_level;
   logic               seed_fend;

   // Propagate address arithmetic.
   logic               restart;
   logic [COL_W-1:0]   col_cur;
   logic [ROW_W-1:0]   row_cur;
   logic [PROD_W-1:0]  src_wide, src_plus, dst_limit, dst_wide;
   logic [WIDTH_W-1:0] col_inc;
   logic [HEIGHT_W-1:0] row_inc;
   logic               prop_fend;

   // Read-modify results.
   logic [LEVEL_W-1:0] rd_clean, new_lvl, dst_out_lvl;

   logic [WIDTH_W-1:0]  csr_width;
   logic [HEIGHT_W-1:0] csr_height;

   assign out_free   = !out_valid_ff || rsp_chan.ready;
   assign req_ready  = (state_ff == ST_IDLE) && out_free;
   assign req_accept = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;

   // ---------------------------------------------------------------- seed
   assign total  = PROD_W'(width_ff) * PROD_W'(height_ff);
   assign bottom = total - PROD_W'(width_ff);

   always_comb begin
      seed_pos   = (PROD_W'(seed_ff) >= total) ? '0 : seed_ff;
      seed_level = (PROD_W'(seed_pos) >= bottom) ? TOP_LEVEL : '0;
      seed_fend  = (PROD_W'(seed_pos) + PROD_W'(1)) == total;
      seed_in    = seed_ff;
      if (load_seed) begin
         seed_in = seed_fend ? '0 : seed_pos + CELL_W'(1);
      end
   end

   // ---------------------------------------------------------------- propagate
   always_comb begin
      restart = (WIDTH_W'(col_ff) >= width_ff) || (row_ff == '0) ||
                (HEIGHT_W'(row_ff) >= height_ff);
      col_cur = restart ? '0 : col_ff;
      row_cur = restart ? ROW_W'(1) : row_ff;

      src_wide  = PROD_W'(row_cur) * PROD_W'(width_ff) + PROD_W'(col_cur);
      src_plus  = src_wide + PROD_W'(1);
      dst_limit = PROD_W'(width_ff) + PROD_W'(req_chan.rand_value);
      // A destination that would land before the field becomes cell 0.
      dst_wide  = (src_plus < dst_limit) ? '0 : src_plus - dst_limit;

      col_inc   = WIDTH_W'(col_cur) + WIDTH_W'(1);
      row_inc   = HEIGHT_W'(row_cur) + HEIGHT_W'(1);
      prop_fend = (col_inc == width_ff) && (row_inc == height_ff);

      col_in = col_ff;
      row_in = row_ff;
      if (load_prop) begin
         if (row_inc >= height_ff) begin
            row_in = ROW_W'(1);
            col_in = (col_inc >= width_ff) ? '0 : col_inc[COL_W-1:0];
         end else begin
            row_in = row_inc[ROW_W-1:0];
            col_in = col_cur;
         end
      end
   end

   always_comb begin
      src_in   = src_ff;
      dst_in   = dst_ff;
      decay_in = decay_ff;
      fend_in  = fend_ff;
      if (load_prop) begin
         src_in   = src_wide[CELL_W-1:0];
         dst_in   = dst_wide[CELL_W-1:0];
         decay_in = req_chan.rand_value[0];
         fend_in  = prop_fend;
      end
   end

   // ---------------------------------------------------------------- modify
   always_comb begin
      rd_clean = (rd_data_ff > TOP_LEVEL) ? '0 : rd_data_ff;
      if (rd_data_ff > TOP_LEVEL || rd_data_ff < LEVEL_W'(decay_ff)) begin
         new_lvl = '0;
      end else begin
         new_lvl = rd_data_ff - LEVEL_W'(decay_ff);
      end
      dst_out_lvl = (state_ff == ST_MODIFY) ? new_lvl : dst_lvl_ff;

      dst_lvl_in = dst_lvl_ff;
      src_lvl_in = src_lvl_ff;
      if (state_ff == ST_MODIFY) begin
         dst_lvl_in = new_lvl;
         // With a one-column field the source can be its own destination.
         src_lvl_in = (src_ff == dst_ff) ? new_lvl : rd_clean;
      end
   end

   // ---------------------------------------------------------------- heat store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         heat_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= heat_mem[src_wide[CELL_W-1:0]];
   end

   // ---------------------------------------------------------------- control
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_chan.operation == OP_PROPAGATE) begin
               state_in = ST_MODIFY;
            end
         end
         ST_MODIFY: begin
            state_in = out_free ? ST_SRC : ST_DST;
         end
         ST_DST: begin
            if (out_free) begin
               state_in = ST_SRC;
            end
         end
         ST_SRC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      load_seed = 1'b0;
      load_prop = 1'b0;
      load_dst  = 1'b0;
      load_src  = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = seed_pos;
      mem_wdata = seed_level;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_chan.operation == OP_SEED) begin
                  load_seed = 1'b1;
                  mem_we    = 1'b1;
               end else begin
                  load_prop = 1'b1;
               end
            end
         end
         ST_MODIFY: begin
            mem_we    = 1'b1;
            mem_waddr = dst_ff;
            mem_wdata = new_lvl;
            load_dst  = out_free;
         end
         ST_DST: begin
            load_dst = out_free;
         end
         ST_SRC: begin
            load_src = out_free;
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------- output register
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_cell_in  = out_cell_ff;
      out_lvl_in   = out_lvl_ff;
      out_last_in  = out_last_ff;
      out_fend_in  = out_fend_ff;
      if (load_seed) begin
         out_valid_in = 1'b1;
         out_cell_in  = seed_pos;
         out_lvl_in   = seed_level;
         out_last_in  = 1'b1;
         out_fend_in  = seed_fend;
      end else if (load_dst) begin
         out_valid_in = 1'b1;
         out_cell_in  = dst_ff;
         out_lvl_in   = dst_out_lvl;
         out_last_in  = 1'b0;
         out_fend_in  = fend_ff;
      end else if (load_src) begin
         out_valid_in = 1'b1;
         out_cell_in  = src_ff;
         out_lvl_in   = src_lvl_ff;
         out_last_in  = 1'b1;
         out_fend_in  = fend_ff;
      end
   end

   fep_palette u_palette (
      .level      (out_lvl_ff),
      .glyph_code (rsp_chan.glyph_code),
      .foreground (rsp_chan.foreground),
      .background (rsp_chan.background)
   );

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.cell_index  = out_cell_ff;
   assign rsp_chan.heat_level  = out_lvl_ff;
   assign rsp_chan.last_of_run = out_last_ff;
   assign rsp_chan.frame_end   = out_fend_ff;

   // ---------------------------------------------------------------- configuration
   always_comb begin
      csr_width = csr_chan.data[WIDTH_W-1:0];
      if (csr_width < WIDTH_MIN) begin
         csr_width = WIDTH_MIN;
      end else if (csr_width > WIDTH_MAX) begin
         csr_width = WIDTH_MAX;
      end
      csr_height = csr_chan.data[HEIGHT_W-1:0];
      if (csr_height < HEIGHT_MIN) begin
         csr_height = HEIGHT_MIN;
      end else if (csr_height > HEIGHT_MAX) begin
         csr_height = HEIGHT_MAX;
      end

      width_in  = width_ff;
      height_in = height_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_FRAME_WIDTH: begin
               width_in = csr_width;
            end
            CSR_FRAME_HEIGHT: begin
               height_in = csr_height;
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         seed_ff      <= '0;
         col_ff       <= '0;
         row_ff       <= ROW_W'(1);
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         seed_ff      <= seed_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      decay_ff    <= decay_in;
      fend_ff     <= fend_in;
      dst_lvl_ff  <= dst_lvl_in;
      src_lvl_ff  <= src_lvl_in;
      out_cell_ff <= out_cell_in;
      out_lvl_ff  <= out_lvl_in;
      out_last_ff <= out_last_in;
      out_fend_ff <= out_fend_in;
   end

   // ---------------------------------------------------------------- assertions
   a_modify_follows_accept: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MODIFY |-> $past(req_accept))
      else $error("store write without an accepted propagate item");

   a_source_result_last: assert property (@(posedge clock) disable iff (reset)
      load_src |=> rsp_chan.valid && rsp_chan.last_of_run)
      else $error("source result not marked as last of its item");

   a_destination_not_last: assert property (@(posedge clock) disable iff (reset)
      load_dst |=> rsp_chan.valid && !rsp_chan.last_of_run)
      else $error("destination result marked as last of its item");

   a_level_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> out_lvl_ff <= TOP_LEVEL)
      else $error("reported heat level above the top level");

endmodule

`default_nettype wire
